/* rtl/fac_pkg.sv */
// fac_pkg: shared widths, reset values, state and pipeline types for the
// frame autocorrelation block; no dependencies
package fac_pkg;

    localparam int MAX_LENGTH_DEF = 64;
    localparam int SMP_W          = 16;
    localparam int CFG_W          = 7;
    localparam int VAL_W          = 38;
    localparam int LAG_W          = 6;
    localparam int PROD_W         = 2 * SMP_W;

    localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(64);
    localparam logic [CFG_W-1:0] LEN_MIN   = CFG_W'(2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    // control flags that ride along with one product term
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic last_lag;
    } t_term;

endpackage

/* rtl/frame_autocorrelation.sv */
// frame_autocorrelation: top level, frame fill control and lag sequencer
// depends on fac_pkg and fac_datapath
//
//  channel   direction  handshake        payload
//  sample    in         start, busy      i_sample
//  result    out        o_valid strobe   o_lag_value, o_lag_index, o_last_lag
//  config    in         i_cfg_we         i_cfg_data (frame length)
//
// one sample beat per cycle while filling; the beat that completes a frame of
// L samples starts issue of L*(L+1)/2 product terms on the single multiplier,
// which pass the memory, multiply and accumulate stages. busy goes high after
// that beat and stays high until the last product term leaves the pipeline;
// no sample is accepted while busy. results are strobed and cannot be stalled.
// synchronous reset clears the fill count and sets the frame length to 64.
module frame_autocorrelation #(
    parameter int MAX_LENGTH = fac_pkg::MAX_LENGTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [fac_pkg::SMP_W-1:0] i_sample,
    input  logic                             i_cfg_we,
    input  logic [fac_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                             o_valid,
    output logic signed [fac_pkg::VAL_W-1:0] o_lag_value,
    output logic [fac_pkg::LAG_W-1:0]        o_lag_index,
    output logic                             o_last_lag
);

    localparam int AW = $clog2(MAX_LENGTH);
    localparam int LW = $clog2(MAX_LENGTH + 1);

    fac_pkg::t_state             r_state;
    fac_pkg::t_state             n_state;
    logic [fac_pkg::CFG_W-1:0]   r_cfg_len;
    logic [LW-1:0]               eff_len;
    logic [LW-1:0]               r_len;
    logic [LW-1:0]               r_fill;
    logic [LW-1:0]               n_fill;
    logic [AW-1:0]               r_k;
    logic [AW-1:0]               r_i;
    logic                        accept;
    logic                        frame_done;
    logic                        term_last;
    logic                        lag_last;
    logic                        issue;
    logic                        pipe_busy;
    fac_pkg::t_term              term;

    always_comb begin
        if (r_cfg_len < fac_pkg::LEN_MIN) begin
            eff_len = LW'(fac_pkg::LEN_MIN);
        end else if (r_cfg_len > fac_pkg::CFG_W'(MAX_LENGTH)) begin
            eff_len = LW'(MAX_LENGTH);
        end else begin
            eff_len = LW'(r_cfg_len);
        end
    end

    assign accept     = start && !busy;
    assign n_fill     = r_fill + LW'(1);
    assign frame_done = accept && (n_fill >= eff_len);
    assign term_last  = (LW'(r_i) + LW'(r_k)) == (r_len - LW'(1));
    assign lag_last   = LW'(r_k) == (r_len - LW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fac_pkg::S_IDLE: begin
                if (frame_done) begin
                    n_state = fac_pkg::S_RUN;
                end
            end
            fac_pkg::S_RUN: begin
                if (term_last && lag_last) begin
                    n_state = fac_pkg::S_DRAIN;
                end
            end
            fac_pkg::S_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = fac_pkg::S_IDLE;
                end
            end
            default: n_state = fac_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        case (r_state)
            fac_pkg::S_IDLE: begin
                busy  = 1'b0;
                issue = 1'b0;
            end
            fac_pkg::S_RUN: begin
                busy  = 1'b1;
                issue = 1'b1;
            end
            default: begin
                busy  = 1'b1;
                issue = 1'b0;
            end
        endcase
    end

    always_comb begin
        term.valid    = issue;
        term.first    = r_i == '0;
        term.last     = term_last;
        term.last_lag = lag_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fac_pkg::S_IDLE;
            r_cfg_len <= fac_pkg::LEN_RESET;
            r_len     <= LW'(MAX_LENGTH);
            r_fill    <= '0;
            r_k       <= '0;
            r_i       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg_len <= i_cfg_data;
            end
            if (accept) begin
                r_fill <= frame_done ? '0 : n_fill;
            end
            if (frame_done) begin
                r_len <= eff_len;
                r_k   <= '0;
                r_i   <= '0;
            end else if (issue) begin
                if (term_last) begin
                    r_i <= '0;
                    r_k <= r_k + AW'(1);
                end else begin
                    r_i <= r_i + AW'(1);
                end
            end
        end
    end

    fac_datapath #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (accept),
        .i_wr_addr   (r_fill[AW-1:0]),
        .i_wr_data   (i_sample),
        .i_term      (term),
        .i_addr_a    (r_i),
        .i_addr_b    (r_i + r_k),
        .i_lag       (r_k),
        .o_pipe_busy (pipe_busy),
        .o_valid     (o_valid),
        .o_lag_value (o_lag_value),
        .o_lag_index (o_lag_index),
        .o_last_lag  (o_last_lag)
    );

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < LW'(MAX_LENGTH))
        else $error("fill count out of range");

    a_addr_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fac_pkg::S_RUN) |-> (LW'(r_i) + LW'(r_k) < r_len))
        else $error("read beyond frame");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_lag) |-> (o_lag_index == fac_pkg::LAG_W'(r_len - LW'(1))))
        else $error("last lag index mismatch");

    a_frame_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_lag) |=> !o_valid)
        else $error("result beat after last lag");

    a_no_issue_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fac_pkg::S_IDLE) |=> !o_valid || $past(pipe_busy, 1) || o_last_lag)
        else $error("result beat without work");

endmodule

/* rtl/fac_datapath.sv */
// fac_datapath: sample memory with one write and two read ports, shared
// multiplier and accumulator for the lag sums; depends on fac_pkg
module fac_datapath #(
    parameter int MAX_LENGTH = fac_pkg::MAX_LENGTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [$clog2(MAX_LENGTH)-1:0]   i_wr_addr,
    input  logic signed [fac_pkg::SMP_W-1:0] i_wr_data,
    input  fac_pkg::t_term                  i_term,
    input  logic [$clog2(MAX_LENGTH)-1:0]   i_addr_a,
    input  logic [$clog2(MAX_LENGTH)-1:0]   i_addr_b,
    input  logic [$clog2(MAX_LENGTH)-1:0]   i_lag,
    output logic                            o_pipe_busy,
    output logic                            o_valid,
    output logic signed [fac_pkg::VAL_W-1:0] o_lag_value,
    output logic [fac_pkg::LAG_W-1:0]       o_lag_index,
    output logic                            o_last_lag
);

    localparam int AW = $clog2(MAX_LENGTH);

    logic signed [fac_pkg::SMP_W-1:0]  mem [MAX_LENGTH];

    logic signed [fac_pkg::SMP_W-1:0]  r_rd_a;
    logic signed [fac_pkg::SMP_W-1:0]  r_rd_b;
    fac_pkg::t_term                    r_s1;
    logic [AW-1:0]                     r_s1_lag;
    logic signed [fac_pkg::PROD_W-1:0] r_prod;
    fac_pkg::t_term                    r_s2;
    logic [AW-1:0]                     r_s2_lag;
    logic signed [fac_pkg::VAL_W-1:0]  r_acc;
    logic signed [fac_pkg::VAL_W-1:0]  n_acc;
    logic                              r_out_valid;
    logic signed [fac_pkg::VAL_W-1:0]  r_out_value;
    logic [AW-1:0]                     r_out_lag;
    logic                              r_out_last;

    // sample store
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= mem[i_addr_a];
        r_rd_b <= mem[i_addr_b];
    end

    always_comb begin
        if (r_s2.first) begin
            n_acc = fac_pkg::VAL_W'(r_prod);
        end else begin
            n_acc = r_acc + fac_pkg::VAL_W'(r_prod);
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r_s1_lag <= i_lag;
        r_prod   <= r_rd_a * r_rd_b;
        r_s2_lag <= r_s1_lag;
        if (r_s2.valid) begin
            r_acc <= n_acc;
        end
        if (r_s2.valid && r_s2.last) begin
            r_out_value <= n_acc;
            r_out_lag   <= r_s2_lag;
            r_out_last  <= r_s2.last_lag;
        end
    end

    // control stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_s2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1        <= i_term;
            r_s2        <= r_s1;
            r_out_valid <= r_s2.valid && r_s2.last;
        end
    end

    assign o_pipe_busy = r_s1.valid || r_s2.valid;
    assign o_valid     = r_out_valid;
    assign o_lag_value = r_out_value;
    assign o_lag_index = fac_pkg::LAG_W'(r_out_lag);
    assign o_last_lag  = r_out_last;

endmodule

/* bench/frame_autocorrelation_tb.sv */
// frame_autocorrelation_tb: self-checking bench for the frame autocorrelation block,
// predicts every lag of each completed frame and checks the strobed results in order
// depends on fac_pkg and frame_autocorrelation
module frame_autocorrelation_tb;

    localparam int CLK_PERIOD    = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_LEN       = fac_pkg::MAX_LENGTH_DEF;
    localparam int SAMPLE_TARGET = 230;

    localparam int PAT_RANDOM   = 0;
    localparam int PAT_EXTREME  = 1;
    localparam int PAT_MOST_NEG = 2;
    localparam int PAT_SMALL    = 3;

    typedef enum logic [1:0] {
        ACT_SAMPLE,
        ACT_LENGTH,
        ACT_SETTLE,
        ACT_GAP
    } t_action;

    typedef struct {
        t_action                   act;
        logic [fac_pkg::SMP_W-1:0] data;
    } t_pending;

    typedef struct {
        logic signed [fac_pkg::VAL_W-1:0] value;
        logic [fac_pkg::LAG_W-1:0]        lag;
        logic                             last;
    } t_lag_result;

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             start      = 1'b0;
    logic signed [fac_pkg::SMP_W-1:0] i_sample   = '0;
    logic                             i_cfg_we   = 1'b0;
    logic [fac_pkg::CFG_W-1:0]        i_cfg_data = '0;
    logic                             busy;
    logic                             o_valid;
    logic signed [fac_pkg::VAL_W-1:0] o_lag_value;
    logic [fac_pkg::LAG_W-1:0]        o_lag_index;
    logic                             o_last_lag;

    t_pending    pending_beats[$];
    t_lag_result expected_lags[$];

    // predictor state
    logic signed [fac_pkg::SMP_W-1:0] frame_samples [MAX_LEN];
    int                               samples_held;
    logic [fac_pkg::CFG_W-1:0]        length_reg;

    int fail_count  = 0;
    int idle_pct    = 0;
    int settle_cnt  = 0;
    int stim_len    = MAX_LEN;
    int queued_smps = 0;

    frame_autocorrelation dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_sample    (i_sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_lag_value (o_lag_value),
        .o_lag_index (o_lag_index),
        .o_last_lag  (o_last_lag)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int clamp_length(input int n);
        if (n < 2) return 2;
        if (n > MAX_LEN) return MAX_LEN;
        return n;
    endfunction

    function automatic void predict_lags(input logic signed [fac_pkg::SMP_W-1:0] smp);
        int                               len;
        t_lag_result                      res;
        logic signed [fac_pkg::VAL_W-1:0] acc;
        len = clamp_length(int'(length_reg));
        if (samples_held < MAX_LEN) begin
            frame_samples[samples_held] = smp;
            samples_held++;
        end
        if (samples_held < len) return;
        for (int k = 0; k < len; k++) begin
            acc = '0;
            for (int i = 0; i + k < len; i++) begin
                acc = acc + frame_samples[i] * frame_samples[i + k];
            end
            res.value = acc;
            res.lag   = fac_pkg::LAG_W'(k);
            res.last  = (k == len - 1);
            expected_lags.push_back(res);
        end
        samples_held = 0;
    endfunction

    function automatic void note_failure(input string msg);
        if (fail_count < 10) $display("%s", msg);
        fail_count++;
    endfunction

    // driver
    always @(posedge i_clk) begin : drive_proc
        logic                             nxt_start;
        logic                             nxt_we;
        logic signed [fac_pkg::SMP_W-1:0] nxt_sample;
        logic [fac_pkg::CFG_W-1:0]        nxt_cfg;
        if (!i_rst_n) begin
            samples_held = 0;
            length_reg   = fac_pkg::LEN_RESET;
            settle_cnt   = 0;
            start    <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            nxt_start  = start;
            nxt_we     = 1'b0;
            nxt_sample = i_sample;
            nxt_cfg    = i_cfg_data;
            if (i_cfg_we) length_reg = i_cfg_data;
            if (start && !busy) begin
                predict_lags(i_sample);
                nxt_start = 1'b0;
            end
            if (!nxt_start && pending_beats.size() > 0) begin
                case (pending_beats[0].act)
                    ACT_GAP: begin
                        idle_pct = int'(pending_beats[0].data);
                        void'(pending_beats.pop_front());
                    end
                    ACT_SETTLE: begin
                        if (expected_lags.size() == 0 && !busy) begin
                            settle_cnt++;
                        end else begin
                            settle_cnt = 0;
                        end
                        if (settle_cnt >= SETTLE_CYCLES) begin
                            settle_cnt = 0;
                            void'(pending_beats.pop_front());
                        end
                    end
                    ACT_LENGTH: begin
                        nxt_we  = 1'b1;
                        nxt_cfg = fac_pkg::CFG_W'(pending_beats[0].data);
                        void'(pending_beats.pop_front());
                    end
                    default: begin
                        if (int'($urandom_range(99)) >= idle_pct) begin
                            nxt_start  = 1'b1;
                            nxt_sample = pending_beats[0].data;
                            void'(pending_beats.pop_front());
                        end
                    end
                endcase
            end
            start      <= nxt_start;
            i_sample   <= nxt_sample;
            i_cfg_we   <= nxt_we;
            i_cfg_data <= nxt_cfg;
        end
    end

    // monitor
    always @(posedge i_clk) begin : watch_proc
        t_lag_result want;
        if (i_rst_n && o_valid) begin
            if (expected_lags.size() == 0) begin
                note_failure($sformatf("unexpected lag beat: value %0d lag %0d last %0b",
                    o_lag_value, o_lag_index, o_last_lag));
            end else begin
                want = expected_lags.pop_front();
                if (want.value !== o_lag_value || want.lag !== o_lag_index ||
                    want.last !== o_last_lag) begin
                    note_failure($sformatf(
                        "lag mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                        want.value, want.lag, want.last, o_lag_value, o_lag_index, o_last_lag));
                end
            end
        end
    end

    task automatic push_sample(input logic [fac_pkg::SMP_W-1:0] v);
        t_pending p;
        p.act  = ACT_SAMPLE;
        p.data = v;
        pending_beats.push_back(p);
        queued_smps++;
    endtask

    // drain first so the register only changes while the block is idle
    task automatic push_length(input int v);
        t_pending p;
        p.act  = ACT_SETTLE;
        p.data = '0;
        pending_beats.push_back(p);
        p.act  = ACT_LENGTH;
        p.data = fac_pkg::SMP_W'(v);
        pending_beats.push_back(p);
        stim_len = clamp_length(v);
    endtask

    task automatic push_gap(input int pct);
        t_pending p;
        p.act  = ACT_GAP;
        p.data = fac_pkg::SMP_W'(pct);
        pending_beats.push_back(p);
    endtask

    task automatic push_frame(input int n, input int pattern);
        logic [fac_pkg::SMP_W-1:0] smp;
        for (int i = 0; i < n; i++) begin
            case (pattern)
                PAT_EXTREME:  smp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                PAT_MOST_NEG: smp = 16'h8000;
                PAT_SMALL:    smp = fac_pkg::SMP_W'($urandom_range(16) - 8);
                default:      smp = fac_pkg::SMP_W'($urandom);
            endcase
            push_sample(smp);
        end
    endtask

    initial begin : stimulus
        int pick;
        int cfg;
        int part;
        int big_frames;
        big_frames = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: shortest frames, extremes, clamping, length lowered mid-frame
        push_gap(0);
        push_length(2);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h8000);
        push_sample(16'h8000);
        push_length(0);
        push_sample(16'hFFFF);
        push_sample(16'h0001);
        push_length(1);
        push_sample(16'h0000);
        push_sample(16'h7FFF);
        push_length(3);
        push_sample(16'h5555);
        push_sample(16'hAAAA);
        push_sample(16'h0001);
        push_length(8);
        push_frame(5, PAT_RANDOM);
        push_length(3);
        push_frame(1, PAT_RANDOM);

        // random segments
        push_length(127);
        push_frame(stim_len, PAT_MOST_NEG);
        push_length(65);
        push_frame(stim_len, PAT_EXTREME);
        big_frames = 2;
        while (queued_smps < SAMPLE_TARGET) begin
            case ($urandom_range(2))
                0:       push_gap(0);
                1:       push_gap(65);
                default: push_gap(20);
            endcase
            pick = $urandom_range(99);
            if (pick < 60)      cfg = $urandom_range(2, 12);
            else if (pick < 78) cfg = $urandom_range(13, 40);
            else if (pick < 86) cfg = $urandom_range(41, 127);
            else if (pick < 94) cfg = $urandom_range(1);
            else                cfg = 64;
            if (clamp_length(cfg) > 40) begin
                if (big_frames >= 4) cfg = $urandom_range(2, 8);
                else big_frames++;
            end
            push_length(cfg);
            repeat ($urandom_range(1, 3)) push_frame(stim_len, $urandom_range(3));
            if ($urandom_range(99) < 25 && stim_len > 2) begin
                part = $urandom_range(1, stim_len - 1);
                push_frame(part, $urandom_range(3));
                push_length($urandom_range(2, part + 1));
                push_frame(1, PAT_RANDOM);
            end
        end

        while (pending_beats.size() != 0 || start) @(posedge i_clk);
        while (expected_lags.size() != 0) @(posedge i_clk);
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_lags.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * 400000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
rtl/fac_pkg.sv
rtl/fac_datapath.sv
rtl/frame_autocorrelation.sv
bench/frame_autocorrelation_tb.sv
